[hdl/simpson_one_third_integrator_macros.svh]
// ----------------------------------------------------------------------------
// Simpson integrator assertion macros
// Shared concurrent assertion forms for the integrator RTL.
// ----------------------------------------------------------------------------
`ifndef SIMPSON_ONE_THIRD_INTEGRATOR_MACROS_SVH
`define SIMPSON_ONE_THIRD_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define SIMP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside of reset.
`define SIMP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/simp_pkg.sv]
// ----------------------------------------------------------------------------
// Simpson integrator package
// Widths, status codes and the request/response types of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package simp_pkg;

  localparam int unsigned BOUND_W       = 26;
  localparam int unsigned COUNT_W       = 13;
  localparam int unsigned RESULT_W      = 32;
  localparam int unsigned MAX_INTERVALS = 4096;

  // Shared divider: left-aligned dividend, remainder as wide as the divisor.
  localparam int unsigned DVD_W  = 36;
  localparam int unsigned DVR_W  = 27;
  localparam int unsigned ITER_W = 6;

  localparam int unsigned RECIP_W = 25;
  localparam int unsigned SUM_W   = 38;
  localparam int unsigned PROD_W  = 52;

  localparam logic [ITER_W-1:0] STEP_ITERS  = 6'd26;
  localparam logic [ITER_W-1:0] RECIP_ITERS = 6'd25;
  localparam logic [ITER_W-1:0] DIV3_ITERS  = 6'd36;

  // 2^40 / (2^16 + x): the top dividend bits 2^40 >> 25 seed the remainder.
  localparam logic [DVR_W-1:0] RECIP_REM_INIT = 27'd32768;
  localparam logic [DVR_W-1:0] ONE_Q16        = 27'd65536;
  localparam logic [DVR_W-1:0] DIVISOR_THREE  = 27'd3;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_BAD_COUNT = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DVR_W-1:0]  divisor;
    logic [DVR_W-1:0]  rem_init;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[hdl/simp_in_if.sv]
// ----------------------------------------------------------------------------
// Simpson integrator input channel
// Valid/ready channel carrying the bounds and the interval count.
// ----------------------------------------------------------------------------
`default_nettype none

interface simp_in_if;
  logic                              valid;
  logic                              ready;
  logic [simp_pkg::BOUND_W-1:0]      lower_bound;
  logic [simp_pkg::BOUND_W-1:0]      upper_bound;
  logic [simp_pkg::COUNT_W-1:0]      interval_count;

  modport source (output valid, output lower_bound, output upper_bound,
                  output interval_count, input ready);
  modport sink   (input valid, input lower_bound, input upper_bound,
                  input interval_count, output ready);
endinterface

`default_nettype wire

[hdl/simp_out_if.sv]
// ----------------------------------------------------------------------------
// Simpson integrator output channel
// Valid/ready channel carrying the integral and the status.
// ----------------------------------------------------------------------------
`default_nettype none

interface simp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [simp_pkg::RESULT_W-1:0] integral;
  logic                                status;

  modport source (output valid, output integral, output status, input ready);
  modport sink   (input valid, input integral, input status, output ready);
endinterface

`default_nettype wire

[hdl/simpson_one_third_integrator.sv]
// ----------------------------------------------------------------------------
// Simpson 1/3 integrator of 1/(1+x)
// Composite Simpson rule over n subintervals, every reciprocal, the step
// and the final division by three taken on one shared serial divider.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake      Payload
//  in_i      in   valid/ready    lower_bound, upper_bound, interval_count
//  out_o     out  valid/ready    integral, status
//
//  From the accepting edge the item runs through the step division, one
//  reciprocal per node (n+1 of them), a shift-and-add over the m bits of the
//  step (m at most 26) and the division by three; the shared divider gives
//  one quotient bit per cycle. A rejected count goes straight to S_DONE and
//  is loaded from there. One item is in work at a time: in_i.ready is high only while idle.
//  A finished result waits in the output register; the next item is taken
//  as soon as that register is loaded, even while out_o is stalled.
//  Reset is asynchronous and active low; no memory needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none
`include "simpson_one_third_integrator_macros.svh"

module simpson_one_third_integrator (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  simp_in_if.sink     in_i,
  simp_out_if.source  out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_RECIP,
    S_MUL,
    S_DIV3,
    S_DONE
  } state_e;

  state_e                               state_q;
  logic [simp_pkg::BOUND_W-1:0]         hi_q;
  logic [simp_pkg::BOUND_W-1:0]         lo_q;
  logic [simp_pkg::COUNT_W-1:0]         n_q;
  logic                                 neg_q;
  logic [simp_pkg::BOUND_W-1:0]         hstep_q;
  logic [simp_pkg::BOUND_W-1:0]         node_q;
  logic [simp_pkg::BOUND_W-1:0]         node_d;
  logic [simp_pkg::COUNT_W-1:0]         idx_q;
  logic [simp_pkg::COUNT_W-1:0]         idx_d;
  logic [simp_pkg::SUM_W-1:0]           sum_q;
  logic [simp_pkg::SUM_W-1:0]           sum_d;
  logic [simp_pkg::PROD_W-1:0]          mcand_q;
  logic [simp_pkg::BOUND_W-1:0]         mplr_q;
  logic [simp_pkg::PROD_W-1:0]          prod_q;
  logic signed [simp_pkg::RESULT_W-1:0] res_q;
  logic                                 stat_q;
  logic                                 out_valid_q;
  logic signed [simp_pkg::RESULT_W-1:0] out_integral_q;
  logic                                 out_status_q;
  simp_pkg::div_req_t                   div_req_q;
  simp_pkg::div_rsp_t                   div_rsp;

  logic                                 accept;
  logic                                 count_ok;
  logic                                 in_neg;
  logic [simp_pkg::BOUND_W-1:0]         span;
  logic [simp_pkg::RECIP_W-1:0]         recip;
  logic [simp_pkg::SUM_W-1:0]           addend;
  logic [simp_pkg::DVD_W-1:0]           mag;
  logic [simp_pkg::RESULT_W-1:0]        mag_sat;
  logic [simp_pkg::RESULT_W-1:0]        res_d;

  function automatic simp_pkg::div_req_t recip_req(input logic [simp_pkg::BOUND_W-1:0] x);
    simp_pkg::div_req_t r;
    r.start    = 1'b1;
    r.dividend = '0;
    r.divisor  = {1'b0, x} + simp_pkg::ONE_Q16;
    r.rem_init = simp_pkg::RECIP_REM_INIT;
    r.iters    = simp_pkg::RECIP_ITERS;
    return r;
  endfunction

  simp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  assign count_ok = (in_i.interval_count != '0) && !in_i.interval_count[0] &&
                    (in_i.interval_count <= simp_pkg::COUNT_W'(simp_pkg::MAX_INTERVALS));
  assign in_neg   = (in_i.upper_bound < in_i.lower_bound);
  assign span     = in_neg ? (in_i.lower_bound - in_i.upper_bound)
                           : (in_i.upper_bound - in_i.lower_bound);

  // End points weigh 1, odd nodes 4, even interior nodes 2.
  assign recip = div_rsp.quotient[simp_pkg::RECIP_W-1:0];
  always_comb begin
    if (idx_q == '0 || idx_q == n_q) begin
      addend = simp_pkg::SUM_W'(recip);
    end else if (idx_q[0]) begin
      addend = simp_pkg::SUM_W'(recip) << 2;
    end else begin
      addend = simp_pkg::SUM_W'(recip) << 1;
    end
  end
  assign sum_d = sum_q + addend;

  // The last node is the upper bound itself, not the accumulated position.
  assign idx_d  = idx_q + 13'd1;
  assign node_d = (idx_d == n_q) ? hi_q
                : (neg_q ? (node_q - hstep_q) : (node_q + hstep_q));

  assign mag = div_rsp.quotient;
  always_comb begin
    if (neg_q) begin
      mag_sat = (mag > 36'h080000000) ? 32'h80000000 : mag[simp_pkg::RESULT_W-1:0];
      res_d   = 32'd0 - mag_sat;
    end else begin
      mag_sat = (mag > 36'h07FFFFFFF) ? 32'h7FFFFFFF : mag[simp_pkg::RESULT_W-1:0];
      res_d   = mag_sat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      hi_q           <= '0;
      lo_q           <= '0;
      n_q            <= '0;
      neg_q          <= 1'b0;
      hstep_q        <= '0;
      node_q         <= '0;
      idx_q          <= '0;
      sum_q          <= '0;
      mcand_q        <= '0;
      mplr_q         <= '0;
      prod_q         <= '0;
      res_q          <= '0;
      stat_q         <= simp_pkg::STATUS_OK;
      out_valid_q    <= 1'b0;
      out_integral_q <= '0;
      out_status_q   <= simp_pkg::STATUS_OK;
      div_req_q      <= '0;
    end else begin
      div_req_q.start <= 1'b0;
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            lo_q  <= in_i.lower_bound;
            hi_q  <= in_i.upper_bound;
            n_q   <= in_i.interval_count;
            neg_q <= in_neg;
            if (count_ok) begin
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= {span, 10'd0};
              div_req_q.divisor  <= simp_pkg::DVR_W'(in_i.interval_count);
              div_req_q.rem_init <= '0;
              div_req_q.iters    <= simp_pkg::STEP_ITERS;
              state_q            <= S_STEP;
            end else begin
              res_q   <= '0;
              stat_q  <= simp_pkg::STATUS_BAD_COUNT;
              state_q <= S_DONE;
            end
          end
        end
        S_STEP: begin
          if (div_rsp.done) begin
            hstep_q   <= div_rsp.quotient[simp_pkg::BOUND_W-1:0];
            node_q    <= lo_q;
            idx_q     <= '0;
            sum_q     <= '0;
            div_req_q <= recip_req(lo_q);
            state_q   <= S_RECIP;
          end
        end
        S_RECIP: begin
          if (div_rsp.done) begin
            sum_q <= sum_d;
            if (idx_q == n_q) begin
              mcand_q <= simp_pkg::PROD_W'(sum_d);
              mplr_q  <= hstep_q;
              prod_q  <= '0;
              state_q <= S_MUL;
            end else begin
              idx_q     <= idx_d;
              node_q    <= node_d;
              div_req_q <= recip_req(node_d);
            end
          end
        end
        S_MUL: begin
          // Shift-and-add over the step bits; ends once no set bit is left.
          if (mplr_q == '0) begin
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= prod_q[simp_pkg::PROD_W-1:16];
            div_req_q.divisor  <= simp_pkg::DIVISOR_THREE;
            div_req_q.rem_init <= '0;
            div_req_q.iters    <= simp_pkg::DIV3_ITERS;
            state_q            <= S_DIV3;
          end else begin
            if (mplr_q[0]) begin
              prod_q <= prod_q + mcand_q;
            end
            mcand_q <= {mcand_q[simp_pkg::PROD_W-2:0], 1'b0};
            mplr_q  <= {1'b0, mplr_q[simp_pkg::BOUND_W-1:1]};
          end
        end
        S_DIV3: begin
          if (div_rsp.done) begin
            res_q   <= res_d;
            stat_q  <= simp_pkg::STATUS_OK;
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q    <= 1'b1;
            out_integral_q <= res_q;
            out_status_q   <= stat_q;
            state_q        <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.integral = out_integral_q;
  assign out_o.status   = out_status_q;

  `SIMP_ASSERT_IMPL(a_error_zero, clk_i, rst_ni, out_valid_q && out_status_q == simp_pkg::STATUS_BAD_COUNT, out_integral_q == '0, "rejected count with nonzero integral")
  `SIMP_ASSERT_IMPL(a_done_in_wait, clk_i, rst_ni, div_rsp.done, state_q == S_STEP || state_q == S_RECIP || state_q == S_DIV3, "divider result outside a wait state")
  `SIMP_ASSERT_IMPL(a_idx_bound, clk_i, rst_ni, state_q == S_RECIP, idx_q <= n_q, "node index beyond interval count")
  `SIMP_ASSERT_NEXT(a_load_output, clk_i, rst_ni, state_q == S_DONE && (!out_valid_q || out_o.ready), out_valid_q && state_q == S_IDLE, "result not loaded into output register")

endmodule

`default_nettype wire

[hdl/simp_div.sv]
// ----------------------------------------------------------------------------
// Simpson integrator shared divider
// Restoring divider, one quotient bit per cycle, with a preset remainder
// and a programmable number of iterations.
// ----------------------------------------------------------------------------
`default_nettype none
`include "simpson_one_third_integrator_macros.svh"

module simp_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire simp_pkg::div_req_t req_i,
  output simp_pkg::div_rsp_t      rsp_o
);

  logic                          busy_q;
  logic                          done_q;
  logic [simp_pkg::ITER_W-1:0]   cnt_q;
  logic [simp_pkg::DVD_W-1:0]    dvd_q;
  logic [simp_pkg::DVD_W-1:0]    quo_q;
  logic [simp_pkg::DVR_W-1:0]    dvr_q;
  logic [simp_pkg::DVR_W-1:0]    rem_q;
  logic [simp_pkg::DVR_W-1:0]    rem_d;
  logic [simp_pkg::DVR_W:0]      shifted;
  logic [simp_pkg::DVR_W:0]      trial;
  logic                          fits;

  // The remainder stays below the divisor, so the shifted value fits one more bit.
  assign shifted = {rem_q, dvd_q[simp_pkg::DVD_W-1]};
  assign fits    = (shifted >= {1'b0, dvr_q});
  assign trial   = shifted - {1'b0, dvr_q};
  assign rem_d   = fits ? trial[simp_pkg::DVR_W-1:0] : shifted[simp_pkg::DVR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvr_q <= req_i.divisor;
      rem_q <= req_i.rem_init;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[simp_pkg::DVD_W-2:0], 1'b0};
      rem_q <= rem_d;
      quo_q <= {quo_q[simp_pkg::DVD_W-2:0], fits};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  `SIMP_ASSERT_IMPL(a_no_restart, clk_i, rst_ni, req_i.start, !busy_q, "divider restarted while busy")
  `SIMP_ASSERT_NEXT(a_done_after_last, clk_i, rst_ni, busy_q && !req_i.start && cnt_q == 6'd1, done_q && !busy_q, "divider did not finish after last iteration")
  `SIMP_ASSERT_IMPL(a_rem_below_divisor, clk_i, rst_ni, busy_q, rem_q < dvr_q, "partial remainder reached the divisor")

endmodule

`default_nettype wire
